// ===== rtl/vdp_pkg.sv =====
`timescale 1ns / 1ps

package vdp_pkg;

	localparam logic [15:0] PORT_READ_INDEX  = 16'h03C7;
	localparam logic [15:0] PORT_WRITE_INDEX = 16'h03C8;
	localparam logic [15:0] PORT_DATA        = 16'h03C9;
	localparam logic [15:0] PORT_STATUS      = 16'h03DA;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic CFG_PAL_EN = 1'b0;
	localparam logic CFG_MASK   = 1'b1;

	localparam logic [1:0] PHASE_RED   = 2'd0;
	localparam logic [1:0] PHASE_GREEN = 2'd1;
	localparam logic [1:0] PHASE_BLUE  = 2'd2;

	localparam logic [5:0] RETRACE_VALUE = 6'd8;

	typedef logic [23:0] color_t;

	typedef struct packed {
		logic       status;
		logic       data_read;
		logic       retrace;
		logic [1:0] phase;
		logic       wr;
		logic [7:0] widx;
		color_t     wcol;
	} item_info_t;

endpackage

// ===== rtl/vdp_req_if.sv =====
`timescale 1ns / 1ps

interface vdp_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] port;
	logic [7:0]  write_data;

	modport source (output valid, output operation, output port, output write_data,
		input ready);
	modport sink (input valid, input operation, input port, input write_data,
		output ready);
endinterface

// ===== rtl/vdp_rsp_if.sv =====
`timescale 1ns / 1ps

interface vdp_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [5:0]  read_data;
	logic        entry_written;
	logic [7:0]  written_index;
	logic [23:0] written_color;

	modport source (output valid, output status, output read_data, output entry_written,
		output written_index, output written_color, input ready);
	modport sink (input valid, input status, input read_data, input entry_written,
		input written_index, input written_color, output ready);
endinterface

// ===== rtl/vga_dac_palette_ports.sv =====
// An accepted transaction moves through the s1 stage and then the output register.
// Throughput: one transaction per cycle unless rsp stalls; the single-port palette
// memory takes one access per transaction, its registered read data consumed in
// the next stage. Reset: asynchronous, active low; clears index, phase, accumulator
// and entry valid bits, enables the palette with mask FF; unwritten entries read 0.
`timescale 1ns / 1ps

module vga_dac_palette_ports
	import vdp_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	vdp_req_if.sink     req,
	vdp_rsp_if.source   rsp
);

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [AW-1:0] addr_map [256];

	for (genvar g = 0; g < 256; g++) begin : g_addr_map
		assign addr_map[g] = AW'(g % PALETTE_ENTRIES);
	end

	logic                       pal_en_q;
	logic [7:0]                 mask_q;
	logic [7:0]                 idx_q;
	logic [1:0]                 phase_q;
	color_t                     acc_q;
	logic [PALETTE_ENTRIES-1:0] vld_q;
	color_t                     pal_mem [PALETTE_ENTRIES];

	logic       v_s1;
	item_info_t info_s1;
	color_t     rdata_s1;
	logic       rvld_s1;

	logic       out_v_q;
	logic       status_q;
	logic [5:0] rd_q;
	logic       wr_q;
	logic [7:0] widx_q;
	color_t     wcol_q;

	logic          adv_s1;
	logic          accept;
	logic [AW-1:0] addr;
	item_info_t    info;
	color_t        acc_new;
	logic [1:0]    phase_cl;
	logic          last_comp;
	logic [7:0]    idx_next;
	logic          mem_we;
	logic [5:0]    comp;

	assign adv_s1    = !out_v_q || rsp.ready;
	assign req.ready = !v_s1 || adv_s1;
	assign accept    = req.valid && req.ready;
	assign addr      = addr_map[idx_q];
	assign phase_cl  = (phase_q == 2'd3) ? PHASE_BLUE : phase_q;
	assign last_comp = (phase_q >= PHASE_BLUE);
	assign idx_next  = (idx_q + 8'd1) & mask_q;

	always_comb begin
		unique case (phase_cl)
			PHASE_RED:   acc_new = acc_q | {16'd0, req.write_data[5:0], 2'd0};
			PHASE_GREEN: acc_new = acc_q | {8'd0, req.write_data[5:0], 10'd0};
			default:     acc_new = acc_q | {req.write_data[5:0], 18'd0};
		endcase
	end

	always_comb begin
		info           = '0;
		info.phase     = phase_cl;
		mem_we         = 1'b0;
		if (req.operation == OP_READ) begin
			if (req.port == PORT_STATUS) begin
				info.retrace = 1'b1;
			end else if (req.port == PORT_DATA && pal_en_q) begin
				info.data_read = 1'b1;
			end else begin
				info.status = STATUS_ERR;
			end
		end else if (!pal_en_q) begin
			info.status = STATUS_ERR;
		end else if (req.port == PORT_DATA) begin
			if (last_comp) begin
				info.wr   = 1'b1;
				info.widx = idx_q;
				info.wcol = acc_new;
				mem_we    = 1'b1;
			end
		end else if (req.port != PORT_READ_INDEX && req.port != PORT_WRITE_INDEX) begin
			info.status = STATUS_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_en_q <= 1'b1;
			mask_q   <= 8'hFF;
			idx_q    <= '0;
			phase_q  <= PHASE_RED;
			acc_q    <= '0;
			vld_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PAL_EN: pal_en_q <= cfg_data[0];
					CFG_MASK:   mask_q   <= cfg_data;
					default:    ;
				endcase
			end
			if (accept && mem_we) begin
				vld_q[addr] <= 1'b1;
			end
			if (accept && pal_en_q) begin
				if (req.operation == OP_READ) begin
					if (req.port == PORT_DATA) begin
						phase_q <= last_comp ? PHASE_RED : phase_q + 2'd1;
						if (last_comp) begin
							idx_q <= idx_next;
						end
					end
				end else if (req.port == PORT_READ_INDEX || req.port == PORT_WRITE_INDEX) begin
					idx_q   <= req.write_data & mask_q;
					phase_q <= PHASE_RED;
					acc_q   <= '0;
				end else if (req.port == PORT_DATA) begin
					if (last_comp) begin
						phase_q <= PHASE_RED;
						acc_q   <= '0;
						idx_q   <= idx_next;
					end else begin
						phase_q <= phase_q + 2'd1;
						acc_q   <= acc_new;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mem_we) begin
				pal_mem[addr] <= acc_new;
			end
			rdata_s1 <= pal_mem[addr];
			rvld_s1  <= vld_q[addr];
			info_s1  <= info;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (req.ready) begin
				v_s1 <= accept;
			end
			if (adv_s1) begin
				out_v_q <= v_s1;
			end
		end
	end

	always_comb begin
		unique case (info_s1.phase)
			PHASE_RED:   comp = rdata_s1[7:2];
			PHASE_GREEN: comp = rdata_s1[15:10];
			default:     comp = rdata_s1[23:18];
		endcase
		if (!rvld_s1) begin
			comp = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1) begin
			status_q <= info_s1.status;
			if (info_s1.retrace) begin
				rd_q <= RETRACE_VALUE;
			end else if (info_s1.data_read) begin
				rd_q <= comp;
			end else begin
				rd_q <= '0;
			end
			wr_q   <= info_s1.wr;
			widx_q <= info_s1.widx;
			wcol_q <= info_s1.wcol;
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.status        = status_q;
	assign rsp.read_data     = rd_q;
	assign rsp.entry_written = wr_q;
	assign rsp.written_index = widx_q;
	assign rsp.written_color = wcol_q;

endmodule

// ===== test/vga_dac_palette_ports_tb.sv =====
`timescale 1ns / 1ps

module vga_dac_palette_ports_tb;
	import vdp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic       status;
		logic [5:0] read_data;
		logic       entry_written;
		logic [7:0] written_index;
		color_t     written_color;
	} dac_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [7:0] cfg_data;

	vdp_req_if req ();
	vdp_rsp_if rsp ();

	vga_dac_palette_ports DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	color_t      pal_shadow [256];
	logic [7:0]  shadow_index;
	logic [1:0]  shadow_phase;
	color_t      shadow_acc;
	logic        shadow_enabled;
	logic [7:0]  shadow_mask;

	dac_result_t expected_results [$];
	int unsigned sent_count;
	int unsigned fail_count;
	int unsigned cycle_count;
	int          burst_left;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// step to the next component; after blue, restart at red and advance the index
	function automatic void next_component();
		if (shadow_phase == PHASE_BLUE) begin
			shadow_phase = PHASE_RED;
			shadow_index = (shadow_index + 8'd1) & shadow_mask;
		end else begin
			shadow_phase = shadow_phase + 2'd1;
		end
	endfunction

	function automatic dac_result_t predict_access(input logic op, input logic [15:0] addr,
		input logic [7:0] wdata);
		dac_result_t r;
		int sh;
		r = '0;
		sh = 2 + 8 * shadow_phase;
		if (op == OP_READ) begin
			if (addr == PORT_STATUS) begin
				r.read_data = RETRACE_VALUE;
			end else if (addr == PORT_DATA && shadow_enabled) begin
				r.read_data = 6'(pal_shadow[shadow_index] >> sh);
				next_component();
			end else begin
				r.status = STATUS_ERR;
			end
		end else if (!shadow_enabled) begin
			r.status = STATUS_ERR;
		end else if (addr == PORT_READ_INDEX || addr == PORT_WRITE_INDEX) begin
			shadow_index = wdata & shadow_mask;
			shadow_phase = PHASE_RED;
			shadow_acc = '0;
		end else if (addr == PORT_DATA) begin
			shadow_acc = shadow_acc | (color_t'(wdata[5:0]) << sh);
			if (shadow_phase == PHASE_BLUE) begin
				pal_shadow[shadow_index] = shadow_acc;
				r.entry_written = 1'b1;
				r.written_index = shadow_index;
				r.written_color = shadow_acc;
				shadow_acc = '0;
			end
			next_component();
		end else begin
			r.status = STATUS_ERR;
		end
		return r;
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 7))
			0: return PORT_READ_INDEX;
			1: return PORT_WRITE_INDEX;
			2: return PORT_DATA;
			3: return PORT_STATUS;
			4: return PORT_DATA ^ (16'd1 << $urandom_range(0, 15));
			5: return PORT_STATUS ^ (16'd1 << $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] wdata);
		int gap;
		@(negedge clk);
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.operation <= op;
		req.port <= addr;
		req.write_data <= wdata;
		do @(posedge clk); while (!req.ready);
		expected_results.push_back(predict_access(op, addr, wdata));
		sent_count++;
	endtask

	// drop valid and let every outstanding transaction return
	task automatic wait_idle();
		@(negedge clk);
		req.valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PAL_EN)
			shadow_enabled = value[0];
		else
			shadow_mask = value;
	endtask

	task automatic apply_dac_config(input logic en, input logic [7:0] mask);
		wait_idle();
		write_register(CFG_PAL_EN, {7'($urandom), en});
		write_register(CFG_MASK, mask);
	endtask

	initial begin
		int hold;
		logic level;
		rsp.ready = 1'b0;
		hold = 0;
		level = 1'b0;
		forever begin
			@(negedge clk);
			if (hold <= 0) begin
				level = ~level;
				if (!level)
					hold = $urandom_range(1, 6);
				else if ($urandom_range(0, 3) == 0)
					hold = $urandom_range(40, 120);
				else
					hold = $urandom_range(1, 20);
			end
			hold--;
			rsp.ready <= level;
		end
	end

	always @(posedge clk) begin
		dac_result_t exp_res;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected transaction on the response channel");
				fail_count++;
			end else begin
				exp_res = expected_results.pop_front();
				if (rsp.status !== exp_res.status) begin
					$error("status: expected %0d, got %0d", exp_res.status, rsp.status);
					fail_count++;
				end
				if (rsp.read_data !== exp_res.read_data) begin
					$error("read_data: expected %0d, got %0d", exp_res.read_data, rsp.read_data);
					fail_count++;
				end
				if (rsp.entry_written !== exp_res.entry_written) begin
					$error("entry_written: expected %0d, got %0d", exp_res.entry_written,
						rsp.entry_written);
					fail_count++;
				end
				if (rsp.written_index !== exp_res.written_index) begin
					$error("written_index: expected %0d, got %0d", exp_res.written_index,
						rsp.written_index);
					fail_count++;
				end
				if (rsp.written_color !== exp_res.written_color) begin
					$error("written_color: expected %06h, got %06h", exp_res.written_color,
						rsp.written_color);
					fail_count++;
				end
			end
		end
	end

	task automatic test_port_accesses();
		send_access(OP_READ, PORT_STATUS, 8'hFF);
		send_access(OP_READ, PORT_DATA, 8'h00);
		send_access(OP_WRITE, PORT_WRITE_INDEX, 8'hFF);
		send_access(OP_WRITE, PORT_DATA, 8'hFF);
		send_access(OP_READ, PORT_DATA, 8'h55);
		send_access(OP_WRITE, PORT_DATA, 8'h00);
		send_access(OP_WRITE, PORT_READ_INDEX, 8'hFF);
		repeat (3) send_access(OP_READ, PORT_DATA, 8'($urandom));
		send_access(OP_WRITE, PORT_WRITE_INDEX, 8'h80);
		send_access(OP_WRITE, PORT_DATA, 8'h2A);
		send_access(OP_WRITE, PORT_DATA, 8'h15);
		send_access(OP_WRITE, PORT_DATA, 8'hC0);
		send_access(OP_READ, 16'hFFFF, 8'($urandom));
		send_access(OP_READ, 16'h0000, 8'($urandom));
		send_access(OP_READ, PORT_READ_INDEX, 8'($urandom));
		send_access(OP_READ, PORT_WRITE_INDEX, 8'($urandom));
		send_access(OP_WRITE, PORT_STATUS, 8'hA5);
		send_access(OP_WRITE, 16'hFFFF, 8'h5A);
		send_access(OP_WRITE, 16'h03CA, 8'h3C);
	endtask

	task automatic test_palette_disabled();
		apply_dac_config(1'b0, 8'hFF);
		send_access(OP_WRITE, PORT_DATA, 8'h3F);
		send_access(OP_READ, PORT_DATA, 8'($urandom));
		send_access(OP_READ, PORT_STATUS, 8'($urandom));
		send_access(OP_WRITE, PORT_WRITE_INDEX, 8'h10);
	endtask

	task automatic test_index_mask();
		apply_dac_config(1'b1, 8'h00);
		send_access(OP_WRITE, PORT_WRITE_INDEX, 8'hFF);
		repeat (3) send_access(OP_WRITE, PORT_DATA, 8'hFF);
		apply_dac_config(1'b1, 8'h0F);
		send_access(OP_WRITE, PORT_READ_INDEX, 8'hFF);
		repeat (3) send_access(OP_WRITE, PORT_DATA, 8'($urandom));
		send_access(OP_READ, PORT_DATA, 8'($urandom));
	endtask

	task automatic run_random_phase(input int unsigned n_items);
		int unsigned target;
		target = sent_count + n_items;
		while (sent_count < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					send_access(OP_WRITE, $urandom_range(0, 1) ? PORT_READ_INDEX : PORT_WRITE_INDEX,
						8'($urandom));
					repeat ($urandom_range(1, 4) * 3) begin
						if ($urandom_range(0, 7) == 0)
							send_access(OP_READ, $urandom_range(0, 1) ? PORT_DATA : PORT_STATUS,
								8'($urandom));
						send_access(OP_WRITE, PORT_DATA, 8'($urandom));
					end
				end
				4, 5: begin
					send_access(OP_WRITE, $urandom_range(0, 1) ? PORT_READ_INDEX : PORT_WRITE_INDEX,
						8'($urandom));
					repeat ($urandom_range(1, 4) * 3) begin
						if ($urandom_range(0, 9) == 0)
							send_access(OP_READ, PORT_STATUS, 8'($urandom));
						send_access(OP_READ, PORT_DATA, 8'($urandom));
					end
				end
				6: begin
					send_access(OP_WRITE, PORT_WRITE_INDEX, 8'($urandom));
					repeat ($urandom_range(1, 2)) send_access(OP_WRITE, PORT_DATA, 8'($urandom));
				end
				7, 8: begin
					repeat ($urandom_range(1, 6))
						send_access(1'($urandom), pick_port(), 8'($urandom));
				end
				default: begin
					repeat ($urandom_range(1, 9)) send_access(OP_WRITE, PORT_DATA, 8'($urandom));
				end
			endcase
		end
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 10; i++) begin
			case (i)
				0: apply_dac_config(1'b1, 8'hFF);
				1: apply_dac_config(1'b1, 8'h00);
				2: apply_dac_config(1'b0, 8'h3F);
				3: apply_dac_config(1'b1, 8'h01);
				4: apply_dac_config(1'b1, 8'h07);
				5: apply_dac_config(1'b1, 8'hFF);
				default: apply_dac_config($urandom_range(0, 5) != 0, 8'($urandom));
			endcase
			run_random_phase(125);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_PAL_EN;
		cfg_data = 8'h00;
		req.valid = 1'b0;
		req.operation = OP_READ;
		req.port = 16'h0000;
		req.write_data = 8'h00;
		for (int i = 0; i < 256; i++) pal_shadow[i] = '0;
		shadow_index = 8'h00;
		shadow_phase = PHASE_RED;
		shadow_acc = '0;
		shadow_enabled = 1'b1;
		shadow_mask = 8'hFF;
		sent_count = 0;
		fail_count = 0;
		cycle_count = 0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_port_accesses();
		test_palette_disabled();
		test_index_mask();
		test_random_traffic();

		wait_idle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
